### hdl/i2cmts_pkg.sv
// Shared types and constants for the I2C master transaction sequencer.
// No dependencies; imported by the decode, queue and top-level modules.
package i2cmts_pkg;

   // Command codes carried by one request transaction
   typedef enum logic [2:0] {
      CMD_BEGIN   = 3'd0,
      CMD_END     = 3'd1,
      CMD_REQUEST = 3'd2,
      CMD_WRITE   = 3'd3,
      CMD_READ    = 3'd4
   } cmd_type;

   // Bus operation codes carried by one response transaction
   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_WRITE = 3'd1,
      OP_READ  = 3'd2,
      OP_STOP  = 3'd3,
      OP_DONE  = 3'd4
   } op_type;

   // Sequencer phase
   typedef enum logic [1:0] {
      PH_INIT    = 2'd0,
      PH_WRITE   = 2'd1,
      PH_READ    = 2'd2,
      PH_STOPPED = 2'd3
   } phase_type;

   localparam logic [2:0] NACK_ADDR    = 3'b010;
   localparam logic [2:0] NACK_DATA    = 3'b100;
   localparam logic       ADDR_RD_BIT  = 1'b1;
   localparam logic       ADDR_WR_BIT  = 1'b0;
   localparam logic [7:0] RET_STOPPED  = 8'hFF;
   localparam int         MAX_ITEMS    = 4;

   // One request transaction as held in the input register
   typedef struct packed {
      logic [2:0] command;
      logic [6:0] target_addr;
      logic [7:0] data_byte;
      logic [7:0] byte_count;
      logic       send_stop;
      logic       immediate_write;
      logic       address_ack;
      logic       data_ack;
      logic [7:0] read_value;
   } req_type;

   // One response transaction
   typedef struct packed {
      logic [2:0] bus_op;
      logic [7:0] bus_byte;
      logic       master_ack;
      logic [7:0] return_value;
      logic [2:0] status_bits;
      logic [7:0] bytes_left;
      logic       last;
   } rsp_type;

   // All responses caused by one request, with their count (1 to 4)
   typedef struct packed {
      rsp_type [MAX_ITEMS-1:0] items;
      logic [2:0]              count;
   } batch_type;

   // Sequencer state
   typedef struct packed {
      phase_type  phase;
      logic [6:0] slave_address;
      logic [7:0] remaining_count;
      logic       stop_after_read;
      logic [2:0] nack_status;
   } seq_state_type;

endpackage

### hdl/i2cmts_decode.sv
// Command decode: turns one registered request and the current sequencer
// state into its batch of response transactions and the next state. Uses i2cmts_pkg.
module i2cmts_decode (
   input  i2cmts_pkg::req_type       req,
   input  i2cmts_pkg::seq_state_type cur,
   output i2cmts_pkg::seq_state_type nxt,
   output i2cmts_pkg::batch_type     batch
);
   import i2cmts_pkg::*;

   always_comb begin
      logic [1:0] n;
      logic [7:0] ret;
      logic       ok;
      rsp_type    bus;

      nxt   = cur;
      batch = '0;
      n     = 2'd0;
      ret   = 8'd0;
      ok    = 1'b1;
      bus   = '0;

      case (req.command)
         CMD_BEGIN: begin
            nxt.slave_address   = req.target_addr;
            bus = '0; bus.bus_op = OP_START;
            batch.items[n] = bus; n = n + 2'd1;
            nxt.remaining_count = 8'd1;
            nxt.phase           = PH_INIT;
            nxt.stop_after_read = 1'b0;
            nxt.nack_status     = 3'd0;
            if (req.immediate_write) begin
               bus = '0; bus.bus_op = OP_WRITE;
               bus.bus_byte = {req.target_addr, ADDR_WR_BIT};
               batch.items[n] = bus; n = n + 2'd1;
               if (!req.address_ack) nxt.nack_status = nxt.nack_status | NACK_ADDR;
               nxt.phase = PH_WRITE;
            end
            ret = 8'd0;
         end
         CMD_END: begin
            if (cur.phase == PH_INIT) begin
               bus = '0; bus.bus_op = OP_WRITE;
               bus.bus_byte = {cur.slave_address, ADDR_RD_BIT};
               batch.items[n] = bus; n = n + 2'd1;
               if (!req.address_ack) nxt.nack_status = nxt.nack_status | NACK_ADDR;
            end
            bus = '0; bus.bus_op = OP_STOP;
            batch.items[n] = bus; n = n + 2'd1;
            nxt.phase = PH_STOPPED;
            ret = {5'd0, nxt.nack_status};
         end
         CMD_REQUEST: begin
            nxt.slave_address   = req.target_addr;
            nxt.remaining_count = req.byte_count;
            if (req.send_stop) nxt.stop_after_read = 1'b1;
            if (cur.phase == PH_STOPPED) begin
               bus = '0; bus.bus_op = OP_START;
               batch.items[n] = bus; n = n + 2'd1;
               nxt.phase = PH_INIT;
            end
            if (nxt.phase == PH_INIT) begin
               // send the read address
               bus = '0; bus.bus_op = OP_WRITE;
               bus.bus_byte = {req.target_addr, ADDR_RD_BIT};
               batch.items[n] = bus; n = n + 2'd1;
               nxt.phase = PH_READ;
               if (!req.address_ack) begin
                  nxt.nack_status = nxt.nack_status | NACK_ADDR;
                  bus = '0; bus.bus_op = OP_STOP;
                  batch.items[n] = bus; n = n + 2'd1;
                  nxt.phase           = PH_STOPPED;
                  nxt.remaining_count = 8'd0;
               end
            end
            ret = nxt.remaining_count;
         end
         CMD_WRITE: begin
            if (cur.phase == PH_INIT) begin
               bus = '0; bus.bus_op = OP_WRITE;
               bus.bus_byte = {cur.slave_address, ADDR_WR_BIT};
               batch.items[n] = bus; n = n + 2'd1;
               if (!req.address_ack) begin
                  nxt.nack_status = nxt.nack_status | NACK_ADDR;
                  ok = 1'b0;
               end else begin
                  nxt.phase = PH_WRITE;
               end
            end
            if (ok) begin
               bus = '0; bus.bus_op = OP_WRITE;
               bus.bus_byte = req.data_byte;
               batch.items[n] = bus; n = n + 2'd1;
               if (!req.data_ack) nxt.nack_status = nxt.nack_status | NACK_DATA;
               ret = {7'd0, req.data_ack};
            end
         end
         CMD_READ: begin
            if (cur.phase == PH_STOPPED) begin
               ret = RET_STOPPED;
            end else begin
               if (cur.phase == PH_INIT) begin
                  // send the read address
                  bus = '0; bus.bus_op = OP_WRITE;
                  bus.bus_byte = {cur.slave_address, ADDR_RD_BIT};
                  batch.items[n] = bus; n = n + 2'd1;
                  nxt.phase = PH_READ;
                  if (!req.address_ack) begin
                     nxt.nack_status = nxt.nack_status | NACK_ADDR;
                     bus = '0; bus.bus_op = OP_STOP;
                     batch.items[n] = bus; n = n + 2'd1;
                     nxt.phase           = PH_STOPPED;
                     nxt.remaining_count = 8'd0;
                     ok = 1'b0;
                  end
               end
               if (ok) begin
                  nxt.remaining_count = cur.remaining_count - 8'd1;
                  bus = '0; bus.bus_op = OP_READ;
                  bus.master_ack = (nxt.remaining_count != 8'd0);
                  batch.items[n] = bus; n = n + 2'd1;
                  if (nxt.remaining_count == 8'd0 && cur.stop_after_read) begin
                     bus = '0; bus.bus_op = OP_STOP;
                     batch.items[n] = bus; n = n + 2'd1;
                     nxt.phase = PH_STOPPED;
                  end
                  ret = req.read_value;
               end
            end
         end
         default: begin
            ret = 8'd0;
         end
      endcase

      // close with the done transaction
      bus = '0;
      bus.bus_op       = OP_DONE;
      bus.return_value = ret;
      bus.status_bits  = nxt.nack_status;
      bus.bytes_left   = nxt.remaining_count;
      bus.last         = 1'b1;
      batch.items[n]   = bus;
      batch.count      = {1'b0, n} + 3'd1;
   end

endmodule

### hdl/i2cmts_rsp_queue.sv
// Response queue: holds the batch of one command and hands it out one
// transaction per cycle on the rsp_ channel while rsp_ready is high. Uses i2cmts_pkg.
module i2cmts_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  i2cmts_pkg::batch_type batch,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output i2cmts_pkg::rsp_type   rsp_item
);
   import i2cmts_pkg::*;

   rsp_type [MAX_ITEMS-1:0] items_ff, items_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic [1:0]              idx_ff, idx_in;
   logic                    last_out;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_item  = items_ff[idx_ff];
   assign last_out  = ({1'b0, idx_ff} == (cnt_ff - 3'd1));
   // take a new batch when empty or when the final item leaves this cycle
   assign free      = !rsp_valid || (rsp_ready && last_out);

   always_comb begin
      items_in = items_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      if (rsp_valid && rsp_ready) begin
         if (last_out) begin
            cnt_in = 3'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (load) begin
         items_in = batch.items;
         cnt_in   = batch.count;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      items_ff <= items_in;
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

endmodule

### hdl/i2c_master_transaction_sequencer_top.sv
// Top level of the byte-level I2C master transaction sequencer.
// Depends on i2cmts_pkg, i2cmts_decode and i2cmts_rsp_queue.
//
// Each request transaction is one software command; it yields one to four
// response transactions (bus operations, then a command-done item with
// last set), given out one per cycle while rsp_ready is high. A command is
// registered on accept, decoded combinationally and moved into the response
// queue once the queue is free; its first response is valid once loaded there.
// The queue sets the pace: a command holds it until all its responses (1 to 4)
// are taken, and the next command is taken while the current batch drains.
module i2c_master_transaction_sequencer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [6:0] req_target_addr,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_byte_count,
   input  logic       req_send_stop,
   input  logic       req_immediate_write,
   input  logic       req_address_ack,
   input  logic       req_data_ack,
   input  logic [7:0] req_read_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_bus_op,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_master_ack,
   output logic [7:0] rsp_return_value,
   output logic [2:0] rsp_status_bits,
   output logic [7:0] rsp_bytes_left,
   output logic       rsp_last
);
   import i2cmts_pkg::*;

   req_type       req_ff, req_in;
   logic          req_vld_ff, req_vld_in;
   seq_state_type state_ff, state_in, state_nxt;
   batch_type     batch;
   rsp_type       rsp_item;
   logic          q_free;
   logic          xfer;

   // move the held transaction into the queue when it has room
   assign xfer      = req_vld_ff && q_free;
   assign req_ready = !req_vld_ff || xfer;

   always_comb begin
      req_in     = req_ff;
      req_vld_in = req_vld_ff;
      if (xfer) req_vld_in = 1'b0;
      if (req_valid && req_ready) begin
         req_vld_in             = 1'b1;
         req_in.command         = req_command;
         req_in.target_addr     = req_target_addr;
         req_in.data_byte       = req_data_byte;
         req_in.byte_count      = req_byte_count;
         req_in.send_stop       = req_send_stop;
         req_in.immediate_write = req_immediate_write;
         req_in.address_ack     = req_address_ack;
         req_in.data_ack        = req_data_ack;
         req_in.read_value      = req_read_value;
      end
   end

   // advance the sequencer state on each transfer
   assign state_in = xfer ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (reset) begin
         req_vld_ff <= 1'b0;
         state_ff   <= '{phase: PH_STOPPED, slave_address: 7'd0,
                         remaining_count: 8'd0, stop_after_read: 1'b0,
                         nack_status: 3'd0};
      end else begin
         req_vld_ff <= req_vld_in;
         state_ff   <= state_in;
      end
   end

   i2cmts_decode u_decode (
      .req   (req_ff),
      .cur   (state_ff),
      .nxt   (state_nxt),
      .batch (batch)
   );

   i2cmts_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (xfer),
      .batch     (batch),
      .free      (q_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_bus_op       = rsp_item.bus_op;
   assign rsp_bus_byte     = rsp_item.bus_byte;
   assign rsp_master_ack   = rsp_item.master_ack;
   assign rsp_return_value = rsp_item.return_value;
   assign rsp_status_bits  = rsp_item.status_bits;
   assign rsp_bytes_left   = rsp_item.bytes_left;
   assign rsp_last         = rsp_item.last;

endmodule

### verif/i2cmts_sequence_checker.sv
// Scoreboard for the I2C master transaction sequencer: predicts the bus operations
// of every accepted command and checks each response transaction in order.
// Depends on i2cmts_pkg; instantiated beside the DUT by the testbench top.
module i2cmts_sequence_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [6:0] req_target_addr,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_byte_count,
   input  logic       req_send_stop,
   input  logic       req_immediate_write,
   input  logic       req_address_ack,
   input  logic       req_data_ack,
   input  logic [7:0] req_read_value,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] rsp_bus_op,
   input  logic [7:0] rsp_bus_byte,
   input  logic       rsp_master_ack,
   input  logic [7:0] rsp_return_value,
   input  logic [2:0] rsp_status_bits,
   input  logic [7:0] rsp_bytes_left,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending
);
   import i2cmts_pkg::*;

   // Mismatch lines beyond this many are counted but not printed
   localparam int PRINT_CAP = 200;

   // Predicted sequencer state
   phase_type  bus_phase;
   logic [6:0] tgt_addr;
   logic [7:0] bytes_remaining;
   logic       stop_on_last;
   logic [2:0] nack_flags;

   rsp_type    expected_bus_ops[$];
   rsp_type    observed;
   rsp_type    want;
   req_type    accepted;
   int         rsp_index;

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP)
         $display("mismatch at response %0d: %s", rsp_index, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_val));
   endtask

   task automatic push_bus(input op_type op, input logic [7:0] value, input logic mack);
      rsp_type r;
      r = '0;
      r.bus_op = op;
      r.bus_byte = value;
      r.master_ack = mack;
      expected_bus_ops.push_back(r);
   endtask

   // Done item carries the status and count as they stand at that point
   task automatic push_done(input logic [7:0] ret);
      rsp_type r;
      r = '0;
      r.bus_op = OP_DONE;
      r.return_value = ret;
      r.status_bits = nack_flags;
      r.bytes_left = bytes_remaining;
      r.last = 1'b1;
      expected_bus_ops.push_back(r);
   endtask

   // Send the read address from the pending phase; a NACK stops the bus
   task automatic send_read_address(input logic ack, output logic acked);
      push_bus(OP_WRITE, {tgt_addr, ADDR_RD_BIT}, 1'b0);
      bus_phase = PH_READ;
      acked = ack;
      if (!ack) begin
         nack_flags |= NACK_ADDR;
         push_bus(OP_STOP, 8'h00, 1'b0);
         bus_phase = PH_STOPPED;
         bytes_remaining = 8'h00;
      end
   endtask

   task automatic predict_bus_ops(input req_type cmd);
      logic acked;
      acked = 1'b1;
      case (cmd.command)
         CMD_BEGIN: begin
            tgt_addr = cmd.target_addr;
            push_bus(OP_START, 8'h00, 1'b0);
            bytes_remaining = 8'h01;
            bus_phase = PH_INIT;
            stop_on_last = 1'b0;
            nack_flags = 3'b000;
            if (cmd.immediate_write) begin
               push_bus(OP_WRITE, {tgt_addr, ADDR_WR_BIT}, 1'b0);
               if (!cmd.address_ack)
                  nack_flags |= NACK_ADDR;
               bus_phase = PH_WRITE;
            end
            push_done(8'h00);
         end
         CMD_END: begin
            if (bus_phase == PH_INIT) begin
               push_bus(OP_WRITE, {tgt_addr, ADDR_RD_BIT}, 1'b0);
               if (!cmd.address_ack)
                  nack_flags |= NACK_ADDR;
            end
            push_bus(OP_STOP, 8'h00, 1'b0);
            bus_phase = PH_STOPPED;
            push_done({5'b00000, nack_flags});
         end
         CMD_REQUEST: begin
            tgt_addr = cmd.target_addr;
            bytes_remaining = cmd.byte_count;
            if (cmd.send_stop)
               stop_on_last = 1'b1;
            if (bus_phase == PH_STOPPED) begin
               push_bus(OP_START, 8'h00, 1'b0);
               bus_phase = PH_INIT;
            end
            if (bus_phase == PH_INIT)
               send_read_address(cmd.address_ack, acked);
            push_done(acked ? bytes_remaining : 8'h00);
         end
         CMD_WRITE: begin
            // Pending phase: address goes out first, a NACK ends the command
            if (bus_phase == PH_INIT) begin
               push_bus(OP_WRITE, {tgt_addr, ADDR_WR_BIT}, 1'b0);
               if (!cmd.address_ack) begin
                  nack_flags |= NACK_ADDR;
                  acked = 1'b0;
               end else begin
                  bus_phase = PH_WRITE;
               end
            end
            if (acked) begin
               push_bus(OP_WRITE, cmd.data_byte, 1'b0);
               if (!cmd.data_ack)
                  nack_flags |= NACK_DATA;
               push_done({7'b0000000, cmd.data_ack});
            end else begin
               push_done(8'h00);
            end
         end
         CMD_READ: begin
            if (bus_phase == PH_STOPPED) begin
               push_done(RET_STOPPED);
            end else begin
               if (bus_phase == PH_INIT)
                  send_read_address(cmd.address_ack, acked);
               if (!acked) begin
                  push_done(8'h00);
               end else begin
                  // Count wraps below zero; master ACKs while bytes remain
                  bytes_remaining = bytes_remaining - 8'd1;
                  push_bus(OP_READ, 8'h00, bytes_remaining != 8'h00);
                  if (bytes_remaining == 8'h00 && stop_on_last) begin
                     push_bus(OP_STOP, 8'h00, 1'b0);
                     bus_phase = PH_STOPPED;
                  end
                  push_done(cmd.read_value);
               end
            end
         end
         default: push_done(8'h00);
      endcase
   endtask

   // Check responses first, then predict from the command taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         bus_phase = PH_STOPPED;
         tgt_addr = 7'h00;
         bytes_remaining = 8'h00;
         stop_on_last = 1'b0;
         nack_flags = 3'b000;
         expected_bus_ops.delete();
         rsp_index = 0;
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed.bus_op = rsp_bus_op;
            observed.bus_byte = rsp_bus_byte;
            observed.master_ack = rsp_master_ack;
            observed.return_value = rsp_return_value;
            observed.status_bits = rsp_status_bits;
            observed.bytes_left = rsp_bytes_left;
            observed.last = rsp_last;
            if (expected_bus_ops.size() == 0) begin
               report_mismatch($sformatf("bus_op %0d with nothing pending", rsp_bus_op));
            end else begin
               want = expected_bus_ops.pop_front();
               check_field("bus_op", observed.bus_op, want.bus_op);
               check_field("bus_byte", observed.bus_byte, want.bus_byte);
               check_field("master_ack", observed.master_ack, want.master_ack);
               check_field("return_value", observed.return_value, want.return_value);
               check_field("status_bits", observed.status_bits, want.status_bits);
               check_field("bytes_left", observed.bytes_left, want.bytes_left);
               check_field("last", observed.last, want.last);
            end
            rsp_index++;
         end
         if (req_valid && req_ready) begin
            accepted.command = req_command;
            accepted.target_addr = req_target_addr;
            accepted.data_byte = req_data_byte;
            accepted.byte_count = req_byte_count;
            accepted.send_stop = req_send_stop;
            accepted.immediate_write = req_immediate_write;
            accepted.address_ack = req_address_ack;
            accepted.data_ack = req_data_ack;
            accepted.read_value = req_read_value;
            predict_bus_ops(accepted);
         end
         pending <= expected_bus_ops.size();
      end
   end

endmodule

### verif/tb_i2c_master_transaction_sequencer_top.sv
// Testbench top for the I2C master transaction sequencer: drives directed and
// random command transactions with random idling on both channels.
// Depends on i2cmts_pkg, i2cmts_sequence_checker and the DUT top level.
module tb_i2c_master_transaction_sequencer_top;
   import i2cmts_pkg::*;

   localparam int         CYCLE_LIMIT     = 200000;
   localparam int         ITEMS_PER_PHASE = 140;
   localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;

   logic       clock               = 1'b0;
   logic       reset               = 1'b1;
   logic       req_valid           = 1'b0;
   logic       req_ready;
   logic [2:0] req_command         = 3'd0;
   logic [6:0] req_target_addr     = 7'd0;
   logic [7:0] req_data_byte       = 8'd0;
   logic [7:0] req_byte_count      = 8'd0;
   logic       req_send_stop       = 1'b0;
   logic       req_immediate_write = 1'b0;
   logic       req_address_ack     = 1'b0;
   logic       req_data_ack        = 1'b0;
   logic [7:0] req_read_value      = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready           = 1'b0;
   logic [2:0] rsp_bus_op;
   logic [7:0] rsp_bus_byte;
   logic       rsp_master_ack;
   logic [7:0] rsp_return_value;
   logic [2:0] rsp_status_bits;
   logic [7:0] rsp_bytes_left;
   logic       rsp_last;

   int fail_count;
   int pending;
   int send_idle_pct = 15;
   int rcv_idle_pct  = 68;
   int items_sent    = 0;
   int cycle_count   = 0;

   always #2 clock = ~clock;

   i2c_master_transaction_sequencer_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_target_addr     (req_target_addr),
      .req_data_byte       (req_data_byte),
      .req_byte_count      (req_byte_count),
      .req_send_stop       (req_send_stop),
      .req_immediate_write (req_immediate_write),
      .req_address_ack     (req_address_ack),
      .req_data_ack        (req_data_ack),
      .req_read_value      (req_read_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_bus_op          (rsp_bus_op),
      .rsp_bus_byte        (rsp_bus_byte),
      .rsp_master_ack      (rsp_master_ack),
      .rsp_return_value    (rsp_return_value),
      .rsp_status_bits     (rsp_status_bits),
      .rsp_bytes_left      (rsp_bytes_left),
      .rsp_last            (rsp_last)
   );

   i2cmts_sequence_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_target_addr     (req_target_addr),
      .req_data_byte       (req_data_byte),
      .req_byte_count      (req_byte_count),
      .req_send_stop       (req_send_stop),
      .req_immediate_write (req_immediate_write),
      .req_address_ack     (req_address_ack),
      .req_data_ack        (req_data_ack),
      .req_read_value      (req_read_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_bus_op          (rsp_bus_op),
      .rsp_bus_byte        (rsp_bus_byte),
      .rsp_master_ack      (rsp_master_ack),
      .rsp_return_value    (rsp_return_value),
      .rsp_status_bits     (rsp_status_bits),
      .rsp_bytes_left      (rsp_bytes_left),
      .rsp_last            (rsp_last),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   // Stall the response channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Random fields everywhere, acknowledges mostly given
   function automatic req_type make_req(input logic [2:0] cmd);
      req_type     r;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      r.command = cmd;
      r.address_ack = ($urandom_range(99) < 88);
      r.data_ack = ($urandom_range(99) < 85);
      return r;
   endfunction

   // Hold the transaction on the bus until it is taken
   task automatic send_req(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= r.command;
      req_target_addr <= r.target_addr;
      req_data_byte <= r.data_byte;
      req_byte_count <= r.byte_count;
      req_send_stop <= r.send_stop;
      req_immediate_write <= r.immediate_write;
      req_address_ack <= r.address_ack;
      req_data_ack <= r.data_ack;
      req_read_value <= r.read_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic directed(input logic [2:0] cmd, input logic [6:0] addr,
                           input logic [7:0] data, input logic [7:0] count,
                           input logic sstop, input logic immediate,
                           input logic aack, input logic dack, input logic [7:0] rval);
      req_type r;
      r.command = cmd;
      r.target_addr = addr;
      r.data_byte = data;
      r.byte_count = count;
      r.send_stop = sstop;
      r.immediate_write = immediate;
      r.address_ack = aack;
      r.data_ack = dack;
      r.read_value = rval;
      send_req(r);
   endtask

   // Drop valid and hold off until every predicted response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Mostly well-formed write and read transactions, some stray commands
   task automatic run_random(input int n_items);
      int      goal;
      int      pick;
      int      nbytes;
      req_type r;
      goal = items_sent + n_items;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_req(make_req(CMD_BEGIN));
            nbytes = $urandom_range(4);
            repeat (nbytes) send_req(make_req(CMD_WRITE));
            // now and then a short read before the end
            if ($urandom_range(3) == 0) begin
               r = make_req(CMD_REQUEST);
               r.byte_count = 8'($urandom_range(3, 1));
               send_req(r);
               repeat (r.byte_count) send_req(make_req(CMD_READ));
            end
            send_req(make_req(CMD_END));
         end else if (pick < 80) begin
            r = make_req(CMD_REQUEST);
            if ($urandom_range(9) == 0)
               r.byte_count = 8'($urandom_range(255));
            else
               r.byte_count = 8'($urandom_range(4));
            nbytes = (r.byte_count > 6) ? $urandom_range(6) : r.byte_count;
            send_req(r);
            repeat (nbytes) send_req(make_req(CMD_READ));
            if (!r.send_stop || $urandom_range(3) == 0)
               send_req(make_req(CMD_END));
         end else begin
            send_req(make_req(3'($urandom_range(CMD_UNDEF_LAST))));
         end
      end
   endtask

   // End the run if it hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      int c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Read while stopped returns the stopped marker
      directed(CMD_READ, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      // Undefined commands only report done
      for (c = CMD_UNDEF_FIRST; c <= CMD_UNDEF_LAST; c++)
         directed(3'(c), 7'h7F, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
      // Write while stopped still sends the byte
      directed(CMD_WRITE, 7'h00, 8'hA5, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      // Immediate write address NACKed, then a data NACK, then stop with status
      directed(CMD_BEGIN, 7'h7F, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00);
      directed(CMD_WRITE, 7'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
      directed(CMD_END, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      // Pending address NACKed on the first write; end from the pending phase
      directed(CMD_BEGIN, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      directed(CMD_WRITE, 7'h00, 8'h3C, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
      directed(CMD_END, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      // Request while writing takes its fields but issues no bus operation; last read issues stop
      directed(CMD_BEGIN, 7'h55, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      directed(CMD_WRITE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      directed(CMD_REQUEST, 7'h55, 8'h00, 8'h02, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
      directed(CMD_READ, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'hFF);
      directed(CMD_READ, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      // Zero-count request; the read wraps the count and ACKs
      directed(CMD_REQUEST, 7'h2A, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      directed(CMD_READ, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h81);
      // Requests while reading, full count then one byte
      directed(CMD_REQUEST, 7'h01, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
      directed(CMD_REQUEST, 7'h01, 8'h00, 8'h01, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      directed(CMD_READ, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h5A);
      // Request whose read address is NACKed
      directed(CMD_REQUEST, 7'h33, 8'h00, 8'h02, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
      // Read from the pending phase, address NACKed
      directed(CMD_BEGIN, 7'h12, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      directed(CMD_READ, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h77);
      // Read after an immediate write, then end
      directed(CMD_BEGIN, 7'h40, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00);
      directed(CMD_READ, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'hC3);
      directed(CMD_END, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);

      // Light sender idling, heavy receiver stalls
      run_random(ITEMS_PER_PHASE);
      drain_responses();

      // Swap the idling
      send_idle_pct = 68;
      rcv_idle_pct <= 15;
      run_random(ITEMS_PER_PHASE);
      drain_responses();

      // Full rate on both sides
      send_idle_pct = 0;
      rcv_idle_pct <= 0;
      run_random(ITEMS_PER_PHASE);

      drain_responses();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
